[rtl/bitmap_slab_allocator_assert.svh]
// Assertion macros used by the allocator control FSM
`ifndef BITMAP_SLAB_ALLOCATOR_ASSERT_SVH
`define BITMAP_SLAB_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BSA_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bsa: same-cycle check failed");

// next-cycle implication
`define BSA_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bsa: next-cycle check failed");

`endif

[rtl/bsa_pkg.sv]
`default_nettype none

package bsa_pkg;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_LOCATE,
        S_LREAD,
        S_LCHECK,
        S_SCAN,
        S_SCHECK,
        S_ENC,
        S_RESULT
    } t_state;

    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_VERIFY = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [1:0] ST_BAD_SIZE  = 2'd2;
    localparam logic [1:0] ST_NOT_OWNED = 2'd3;

    localparam logic [1:0] REG_ARENA_BASE = 2'd0;

    typedef struct packed {
        logic accept;
        logic clr;
        logic decode;
        logic locate;
        logic rd_loc;
        logic chk_loc;
        logic scan_rd;
        logic scan_chk;
        logic scan_next;
        logic scan_full;
        logic enc;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic reject;
        logic is_alloc;
        logic any_free;
        logic scan_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

[rtl/bsa_datapath.sv]
`default_nettype none

module bsa_datapath #(
    parameter int PAGE_BYTES       = 4096,
    parameter int MIN_SLOT_BYTES   = 16,
    parameter int ENTRIES_PER_PAGE = 8,
    parameter int PAGES_PER_CLASS  = 4,
    parameter int CLASS_SLOTS      = 14
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  bsa_pkg::t_cmd        i_cmd,
    output bsa_pkg::t_sts        o_sts,
    input  wire  [31:0]          i_arena_base,
    input  wire  [1:0]           i_opcode,
    input  wire  [31:0]          i_request_size,
    input  wire  [31:0]          i_object_address,
    input  wire                  i_out_ready,
    output logic                 o_valid,
    output logic [31:0]          o_result_address,
    output logic [1:0]           o_status,
    output logic                 o_owned
);

    localparam int LOG_PAGE  = $clog2(PAGE_BYTES);
    localparam int LOG_MIN   = $clog2(MIN_SLOT_BYTES);
    localparam int MAX_SLOTS = PAGE_BYTES / MIN_SLOT_BYTES;
    localparam int SW        = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int GRP       = (MAX_SLOTS < 16) ? MAX_SLOTS : 16;
    localparam int GRP_LOG   = $clog2(GRP);
    localparam int GW        = (GRP > 1) ? GRP_LOG : 1;
    localparam int NG        = MAX_SLOTS / GRP;
    localparam int NGW       = (NG > 1) ? $clog2(NG) : 1;
    localparam int CE        = PAGES_PER_CLASS * ENTRIES_PER_PAGE;
    localparam int CW        = (CE > 1) ? $clog2(CE) : 1;
    localparam int ENTRIES   = CLASS_SLOTS * CE;
    localparam int EW        = $clog2(ENTRIES);
    localparam int LW        = $clog2(LOG_PAGE + 2);
    localparam int CLW       = $clog2(CLASS_SLOTS);
    localparam int SPAN      = CE * PAGE_BYTES;

    logic [1:0]           r_op;
    logic [31:0]          r_size;
    logic [31:0]          r_addr;
    logic [LW-1:0]        r_l2a;
    logic [EW-1:0]        r_gbase;
    logic [31:0]          r_cbase;
    logic [CW-1:0]        r_idx;
    logic [EW-1:0]        r_clr;
    logic [EW-1:0]        r_ent;
    logic [SW-1:0]        r_slot;
    logic                 r_inr;
    logic [MAX_SLOTS-1:0] r_mem [ENTRIES];
    logic [MAX_SLOTS-1:0] r_rd_data;
    logic [NG-1:0]        r_grp_any;
    logic [GW-1:0]        r_grp_low [NG];
    logic [31:0]          r_res_addr;
    logic [1:0]           r_res_status;
    logic                 r_res_owned;
    logic                 r_out_valid;
    logic [31:0]          r_out_addr;
    logic [1:0]           r_out_status;
    logic                 r_out_owned;

    logic [LOG_PAGE-1:0]  sm1;
    logic [LW-1:0]        clg;
    logic [LW-1:0]        l2a;
    logic [CLW-1:0]       cls;
    logic [EW-1:0]        gbase;
    logic                 size_bad;
    logic [31:0]          off;
    logic [CW-1:0]        loc_local;
    logic [LW-1:0]        pel;
    logic [MAX_SLOTS-1:0] vmask;
    logic [MAX_SLOTS-1:0] free_bits;
    logic [NG-1:0]        gany;
    logic [GW-1:0]        glow [NG];
    logic [NGW-1:0]       gsel;
    logic [SW-1:0]        eslot;
    logic                 hit;
    logic                 rd_en;
    logic [EW-1:0]        rd_addr;
    logic                 we;
    logic [EW-1:0]        waddr;
    logic [MAX_SLOTS-1:0] wdata;

    // size class
    assign sm1 = LOG_PAGE'(r_size - 32'd1);

    always_comb begin
        clg = '0;
        for (int i = 0; i < LOG_PAGE; i++) begin
            if (sm1[i]) begin
                clg = LW'(i + 1);
            end
        end
    end

    assign l2a      = (clg < LW'(LOG_MIN)) ? LW'(LOG_MIN) : clg;
    assign cls      = CLW'(32'(l2a) + 32'd1);
    assign gbase    = EW'(32'(cls) * 32'(CE));
    assign size_bad = (r_size == 32'd0) || (r_size > 32'(PAGE_BYTES))
                      || ((32'(l2a) + 32'd1) >= 32'(CLASS_SLOTS));

    // address to slot
    assign off       = r_addr - r_cbase;
    assign loc_local = CW'(off >> LOG_PAGE);

    // slot search
    assign pel = LW'(LOG_PAGE) - r_l2a;

    always_comb begin
        for (int s = 0; s < MAX_SLOTS; s++) begin
            vmask[s] = (32'(s) >> pel) == 32'd0;
        end
    end

    assign free_bits = ~r_rd_data & vmask;

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            gany[g] = |free_bits[g*GRP +: GRP];
            glow[g] = '0;
            for (int j = GRP - 1; j >= 0; j--) begin
                if (free_bits[g*GRP + j]) begin
                    glow[g] = GW'(j);
                end
            end
        end
    end

    always_comb begin
        gsel = '0;
        for (int g = NG - 1; g >= 0; g--) begin
            if (r_grp_any[g]) begin
                gsel = NGW'(g);
            end
        end
    end

    assign eslot = (SW'(gsel) << GRP_LOG) | SW'(r_grp_low[gsel]);
    assign hit   = r_inr && r_rd_data[r_slot];

    // bitmap store
    assign rd_en   = i_cmd.scan_rd | i_cmd.rd_loc;
    assign rd_addr = i_cmd.scan_rd ? (r_gbase + EW'(r_idx)) : r_ent;
    assign we      = i_cmd.clr | i_cmd.enc
                     | (i_cmd.chk_loc & hit & (r_op == bsa_pkg::OP_FREE));
    assign waddr   = i_cmd.clr ? r_clr : r_ent;

    always_comb begin
        if (i_cmd.clr) begin
            wdata = '0;
        end else if (i_cmd.enc) begin
            wdata = r_rd_data | (MAX_SLOTS'(1) << eslot);
        end else begin
            wdata = r_rd_data & ~(MAX_SLOTS'(1) << r_slot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= i_opcode;
            r_size <= i_request_size;
            r_addr <= i_object_address;
        end
        if (i_cmd.decode) begin
            r_l2a        <= l2a;
            r_gbase      <= gbase;
            r_cbase      <= i_arena_base + (32'(gbase) << LOG_PAGE);
            r_idx        <= '0;
            r_res_addr   <= '0;
            r_res_owned  <= 1'b0;
            r_res_status <= (r_op == bsa_pkg::OP_NONE) ? bsa_pkg::ST_OK
                                                       : bsa_pkg::ST_BAD_SIZE;
        end
        if (i_cmd.locate) begin
            r_inr  <= off < 32'(SPAN);
            r_ent  <= r_gbase + EW'(loc_local);
            r_slot <= SW'(32'(off[LOG_PAGE-1:0]) >> r_l2a);
        end
        if (i_cmd.scan_rd) begin
            r_ent <= rd_addr;
        end
        if (i_cmd.scan_chk) begin
            r_grp_any <= gany;
            r_grp_low <= glow;
        end
        if (i_cmd.scan_next) begin
            r_idx <= r_idx + CW'(1);
        end
        if (i_cmd.chk_loc) begin
            r_res_addr   <= '0;
            r_res_owned  <= (r_op == bsa_pkg::OP_VERIFY) && hit;
            r_res_status <= ((r_op == bsa_pkg::OP_FREE) && !hit)
                            ? bsa_pkg::ST_NOT_OWNED : bsa_pkg::ST_OK;
        end
        if (i_cmd.scan_full) begin
            r_res_addr   <= '0;
            r_res_owned  <= 1'b0;
            r_res_status <= bsa_pkg::ST_NO_SPACE;
        end
        if (i_cmd.enc) begin
            r_res_addr   <= i_arena_base + (32'(r_ent) << LOG_PAGE)
                            + (32'(eslot) << r_l2a);
            r_res_owned  <= 1'b0;
            r_res_status <= bsa_pkg::ST_OK;
        end
        if (i_cmd.load_out) begin
            r_out_addr   <= r_res_addr;
            r_out_status <= r_res_status;
            r_out_owned  <= r_res_owned;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr <= r_clr + EW'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.clr_done  = r_clr == EW'(ENTRIES - 1);
    assign o_sts.reject    = (r_op == bsa_pkg::OP_NONE) || size_bad;
    assign o_sts.is_alloc  = r_op == bsa_pkg::OP_ALLOC;
    assign o_sts.any_free  = |free_bits;
    assign o_sts.scan_last = r_idx == CW'(CE - 1);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_valid          = r_out_valid;
    assign o_result_address = r_out_addr;
    assign o_status         = r_out_status;
    assign o_owned          = r_out_owned;

endmodule

`default_nettype wire

[rtl/bsa_ctrl.sv]
`default_nettype none

`include "bitmap_slab_allocator_assert.svh"

module bsa_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_ready,
    input  bsa_pkg::t_sts  i_sts,
    output bsa_pkg::t_cmd  o_cmd
);

    bsa_pkg::t_state r_state;
    bsa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bsa_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            bsa_pkg::S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = bsa_pkg::S_IDLE;
                end
            end
            bsa_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = bsa_pkg::S_DECODE;
                end
            end
            bsa_pkg::S_DECODE: begin
                o_cmd.decode = 1'b1;
                if (i_sts.reject) begin
                    n_state = bsa_pkg::S_RESULT;
                end else if (i_sts.is_alloc) begin
                    n_state = bsa_pkg::S_SCAN;
                end else begin
                    n_state = bsa_pkg::S_LOCATE;
                end
            end
            bsa_pkg::S_LOCATE: begin
                o_cmd.locate = 1'b1;
                n_state      = bsa_pkg::S_LREAD;
            end
            bsa_pkg::S_LREAD: begin
                o_cmd.rd_loc = 1'b1;
                n_state      = bsa_pkg::S_LCHECK;
            end
            bsa_pkg::S_LCHECK: begin
                o_cmd.chk_loc = 1'b1;
                n_state       = bsa_pkg::S_RESULT;
            end
            bsa_pkg::S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = bsa_pkg::S_SCHECK;
            end
            bsa_pkg::S_SCHECK: begin
                o_cmd.scan_chk = 1'b1;
                if (i_sts.any_free) begin
                    n_state = bsa_pkg::S_ENC;
                end else if (i_sts.scan_last) begin
                    o_cmd.scan_full = 1'b1;
                    n_state         = bsa_pkg::S_RESULT;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state         = bsa_pkg::S_SCAN;
                end
            end
            bsa_pkg::S_ENC: begin
                o_cmd.enc = 1'b1;
                n_state   = bsa_pkg::S_RESULT;
            end
            bsa_pkg::S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = bsa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bsa_pkg::S_IDLE;
            end
        endcase
    end

    `BSA_NEXT(a_accept_decode, o_cmd.accept, r_state == bsa_pkg::S_DECODE)
    `BSA_IMPL(a_scan_bound, o_cmd.scan_next, !i_sts.scan_last)
    `BSA_NEXT(a_load_idle, o_cmd.load_out, o_ready)

endmodule

`default_nettype wire

[rtl/bitmap_slab_allocator.sv]
// Power-of-two slab allocator over a fixed arena. Each request (allocate,
// free or verify) is taken on the input channel and gives one result on
// the output channel. After reset the slot bitmap store (its
// CLASS_SLOTS*PAGES_PER_CLASS*ENTRIES_PER_PAGE entries, 448 at the
// defaults) is swept clear, one entry per cycle, before the first request
// is taken; the arena base register may be written at any time the block
// is idle. Free and verify pass through decode, locate, bitmap read and
// check before the result is loaded; a rejected request (bad size or
// unused opcode) goes from decode straight to the result. Allocate reads
// the entries of its class in turn, each in a read and a check state,
// until one with a free slot is found and marked taken, or the class is
// full. A result is loaded into the output register once it is free. One
// request is in work at a time and the input is ready again the cycle
// after the result is loaded; a finished result waits in the output
// register while the next request is taken.
`default_nettype none

module bitmap_slab_allocator #(
    parameter int PAGE_BYTES       = 4096,
    parameter int MIN_SLOT_BYTES   = 16,
    parameter int ENTRIES_PER_PAGE = 8,
    parameter int PAGES_PER_CLASS  = 4,
    parameter int CLASS_SLOTS      = 14
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [1:0]  i_opcode,
    input  wire  [31:0] i_request_size,
    input  wire  [31:0] i_object_address,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [31:0] o_result_address,
    output logic [1:0]  o_status,
    output logic        o_owned,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [1:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0]   r_arena_base;
    bsa_pkg::t_cmd cmd;
    bsa_pkg::t_sts sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arena_base <= '0;
        end else if (psel && penable && pwrite) begin
            r_arena_base <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == bsa_pkg::REG_ARENA_BASE) ? r_arena_base : 32'd0;

    bsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    bsa_datapath #(
        .PAGE_BYTES       (PAGE_BYTES),
        .MIN_SLOT_BYTES   (MIN_SLOT_BYTES),
        .ENTRIES_PER_PAGE (ENTRIES_PER_PAGE),
        .PAGES_PER_CLASS  (PAGES_PER_CLASS),
        .CLASS_SLOTS      (CLASS_SLOTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_arena_base     (r_arena_base),
        .i_opcode         (i_opcode),
        .i_request_size   (i_request_size),
        .i_object_address (i_object_address),
        .i_out_ready      (i_ready),
        .o_valid          (o_valid),
        .o_result_address (o_result_address),
        .o_status         (o_status),
        .o_owned          (o_owned)
    );

endmodule

`default_nettype wire

[tb/bitmap_slab_allocator_tb.sv]
`default_nettype none

module bitmap_slab_allocator_tb;

    localparam int PAGE_B   = 4096;
    localparam int MIN_SLOT = 16;
    localparam int EPP      = 8;
    localparam int PPC      = 4;
    localparam int NCLS     = 14;
    localparam int NPAGES   = NCLS * PPC;
    localparam int NENTRIES = NPAGES * EPP;
    localparam logic [31:0] CLASS_SPAN = PPC * EPP * PAGE_B;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] size;
        logic [31:0] addr;
    } t_req;

    typedef struct {
        logic [31:0] addr;
        logic [1:0]  st;
        logic        owned;
    } t_resp;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_opcode;
    logic [31:0] i_request_size;
    logic [31:0] i_object_address;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_result_address;
    logic [1:0]  o_status;
    logic        o_owned;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bitmap_slab_allocator dut (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_opcode, .i_request_size,
        .i_object_address, .o_valid, .i_ready, .o_result_address, .o_status,
        .o_owned, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    // shadow allocator state
    bit [255:0]  slot_map [NENTRIES];
    int unsigned entry_cnt [NENTRIES];
    int unsigned page_cnt [NPAGES];
    logic [31:0] arena_base;

    t_req  pend_reqs [$];
    t_resp due_resps [$];
    int    mismatches;
    int    n_accepted;
    logic [31:0] gen_base;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic bit size_to_class(input logic [31:0] size,
                                         output int sb, output int cls);
        int a;
        a = MIN_SLOT;
        sb = 0;
        cls = 0;
        if (size == 0 || size > PAGE_B)
            return 0;
        while (a < size)
            a = a << 1;
        cls = $clog2(a) + 1;
        sb = a;
        return cls < NCLS;
    endfunction

    function automatic t_resp alloc_predict(input t_req r);
        t_resp o;
        int sb, cls, per_entry, pg, en, sl, lcl;
        logic [31:0] cbase, off;
        bit done;
        o.addr = '0;
        o.st = bsa_pkg::ST_OK;
        o.owned = 1'b0;
        done = 0;
        if (r.op == bsa_pkg::OP_NONE)
            return o;
        if (!size_to_class(r.size, sb, cls)) begin
            o.st = bsa_pkg::ST_BAD_SIZE;
            return o;
        end
        per_entry = PAGE_B / sb;
        cbase = arena_base + cls * CLASS_SPAN;
        if (r.op == bsa_pkg::OP_ALLOC) begin
            o.st = bsa_pkg::ST_NO_SPACE;
            for (int p = 0; p < PPC && !done; p++) begin
                pg = cls * PPC + p;
                if (page_cnt[pg] >= per_entry * EPP)
                    continue;
                done = 1;
                for (int e = 0; e < EPP; e++) begin
                    en = pg * EPP + e;
                    if (entry_cnt[en] >= per_entry)
                        continue;
                    for (int s = 0; s < per_entry; s++) begin
                        if (!slot_map[en][s]) begin
                            slot_map[en][s] = 1'b1;
                            entry_cnt[en]++;
                            page_cnt[pg]++;
                            o.addr = cbase + (p * EPP + e) * PAGE_B + s * sb;
                            o.st = bsa_pkg::ST_OK;
                            break;
                        end
                    end
                    break;
                end
            end
            return o;
        end
        off = r.addr - cbase;
        if (off >= CLASS_SPAN) begin
            if (r.op == bsa_pkg::OP_FREE)
                o.st = bsa_pkg::ST_NOT_OWNED;
            return o;
        end
        lcl = off / PAGE_B;
        pg = cls * PPC + lcl / EPP;
        en = pg * EPP + lcl % EPP;
        sl = (off % PAGE_B) / sb;
        if (sl >= per_entry || !slot_map[en][sl]) begin
            if (r.op == bsa_pkg::OP_FREE)
                o.st = bsa_pkg::ST_NOT_OWNED;
            return o;
        end
        if (r.op == bsa_pkg::OP_FREE) begin
            slot_map[en][sl] = 1'b0;
            if (entry_cnt[en] != 0)
                entry_cnt[en]--;
            if (page_cnt[pg] != 0)
                page_cnt[pg]--;
        end else begin
            o.owned = 1'b1;
        end
        return o;
    endfunction

    // driver: bursts with gaps
    int burst_left = 5;
    int gap_left = 0;
    always @(posedge i_clk) begin
        t_req r;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pend_reqs.size() > 0) begin
                r = pend_reqs.pop_front();
                i_valid <= 1'b1;
                i_opcode <= r.op;
                i_request_size <= r.size;
                i_object_address <= r.addr;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 20);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver: own stall pattern, one long hold-off
    int  stall_left = 0;
    int  hold_left = 0;
    bit  held = 0;
    bit  ready_mode = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (!held && n_accepted >= 150) begin
                held = 1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                if (stall_left == 0) begin
                    stall_left = $urandom_range(5, 60);
                    ready_mode = 1'($urandom_range(0, 1));
                end
                stall_left--;
                i_ready <= ready_mode ? 1'b1 : ($urandom_range(0, 3) != 0);
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_req  r;
        t_resp e;
        if (i_rst_n && i_valid && o_ready) begin
            r.op = i_opcode;
            r.size = i_request_size;
            r.addr = i_object_address;
            due_resps.push_back(alloc_predict(r));
            n_accepted <= n_accepted + 1;
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (due_resps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: addr %h status %0d owned %0d",
                             o_result_address, o_status, o_owned);
            end else begin
                e = due_resps.pop_front();
                if (o_result_address !== e.addr || o_status !== e.st || o_owned !== e.owned) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp addr %h st %0d own %0d, got %h %0d %0d",
                                 e.addr, e.st, e.owned, o_result_address, o_status, o_owned);
                end
            end
        end
    end

    task automatic apb_write(input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= bsa_pkg::REG_ARENA_BASE;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        arena_base = val;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        gen_base = val;
    endtask

    task automatic push_req(input logic [1:0] op, input logic [31:0] size,
                            input logic [31:0] addr);
        t_req r;
        r.op = op;
        r.size = size;
        r.addr = addr;
        pend_reqs.push_back(r);
    endtask

    task automatic drain();
        while (pend_reqs.size() > 0 || i_valid || due_resps.size() > 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_size();
        int k;
        k = $urandom_range(0, 19);
        if (k == 0)
            return $urandom();
        if (k == 1)
            return 0;
        return $urandom_range(1, 1 << $urandom_range(3, 12));
    endfunction

    task automatic rand_req();
        logic [31:0] sz, ad;
        int sb, cls, k;
        k = $urandom_range(0, 99);
        sz = pick_size();
        if (k < 45) begin
            push_req(bsa_pkg::OP_ALLOC, sz, $urandom());
        end else if (k < 90) begin
            if (!size_to_class(sz, sb, cls)) begin
                sb = MIN_SLOT;
                cls = 5;
            end
            ad = gen_base + cls * CLASS_SPAN + $urandom_range(0, 3) * PAGE_B
                 + $urandom_range(0, 3) * sb;
            if ($urandom_range(0, 4) == 0)
                ad = ad + $urandom_range(0, sb - 1);
            push_req(($urandom_range(0, 1) == 0) ? bsa_pkg::OP_FREE : bsa_pkg::OP_VERIFY,
                     sz, ad);
        end else begin
            push_req(2'($urandom_range(0, 3)), $urandom(), $urandom());
        end
    endtask

    initial begin
        logic [31:0] big;
        mismatches = 0;
        n_accepted = 0;
        arena_base = '0;
        gen_base = '0;
        for (int i = 0; i < NENTRIES; i++) begin
            slot_map[i] = '0;
            entry_cnt[i] = 0;
        end
        for (int i = 0; i < NPAGES; i++)
            page_cnt[i] = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_opcode = '0;
        i_request_size = '0;
        i_object_address = '0;
        i_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (460) @(posedge i_clk);

        // directed
        apb_write(32'h0000_0000);
        big = 13 * CLASS_SPAN;
        push_req(bsa_pkg::OP_NONE, 32'd16, 32'd0);
        push_req(bsa_pkg::OP_ALLOC, 32'd0, 32'd0);
        push_req(bsa_pkg::OP_FREE, 32'd4097, 32'd0);
        push_req(bsa_pkg::OP_VERIFY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_req(bsa_pkg::OP_ALLOC, 32'd1, 32'd0);
        push_req(bsa_pkg::OP_ALLOC, 32'd16, 32'd0);
        push_req(bsa_pkg::OP_ALLOC, 32'd17, 32'd0);
        push_req(bsa_pkg::OP_ALLOC, 32'd4096, 32'd0);
        push_req(bsa_pkg::OP_VERIFY, 32'd4096, big);
        push_req(bsa_pkg::OP_VERIFY, 32'd4000, big + 32'd123);
        push_req(bsa_pkg::OP_FREE, 32'd4096, big + 32'd7);
        push_req(bsa_pkg::OP_FREE, 32'd4096, big);
        push_req(bsa_pkg::OP_VERIFY, 32'd4096, big);
        push_req(bsa_pkg::OP_VERIFY, 32'd8, 32'hFFFF_FFFF);
        push_req(bsa_pkg::OP_FREE, 32'd16, 32'hFFFF_FFFF);
        push_req(bsa_pkg::OP_FREE, 32'd3, 5 * CLASS_SPAN + 32'd16);
        push_req(bsa_pkg::OP_VERIFY, 32'd2048, 12 * CLASS_SPAN);
        for (int i = 0; i < 90; i++)
            rand_req();
        drain();

        // full class, then frees; long receiver hold falls in here
        apb_write(32'hFFFF_F000);
        for (int i = 0; i < 34; i++)
            push_req(bsa_pkg::OP_ALLOC, 32'd4096, 32'd0);
        for (int i = 0; i < 8; i++)
            push_req(bsa_pkg::OP_FREE, 32'd4096,
                     gen_base + 13 * CLASS_SPAN + $urandom_range(0, 31) * PAGE_B);
        for (int i = 0; i < 4; i++)
            push_req(bsa_pkg::OP_ALLOC, 32'd3000, 32'd0);
        for (int i = 0; i < 80; i++)
            rand_req();
        drain();

        apb_write({20'($urandom_range(0, 32'hF_FFFF)), 12'h000});
        for (int i = 0; i < 110; i++)
            rand_req();
        drain();

        apb_write(32'hFFFF_FFFF);
        for (int i = 0; i < 110; i++)
            rand_req();
        drain();

        apb_write(32'h0001_0000);
        for (int i = 0; i < 110; i++)
            rand_req();
        drain();

        if (mismatches == 0 && due_resps.size() == 0)
            $display("bitmap_slab_allocator_tb: clean");
        else
            $display("bitmap_slab_allocator_tb: errors");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("bitmap_slab_allocator_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire
